/* rtl/core/lsbst_pkg.sv */
// ----------------------------------------------------------------------------
// lsbst_pkg
// Shared types, field widths, codes and helpers for the LSB steganography
// embed/extract block.
// ----------------------------------------------------------------------------
package lsbst_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int BPC_W      = 2;
  localparam int CH_W       = 3;
  localparam int PIX_W      = 25;
  localparam int PAY_W      = 24;
  localparam int DONE_W     = PAY_W + 3;   // payload length in bits
  localparam int GFILL_W    = 3;
  localparam int ST_W       = 2;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PIX_W;

  // Sizing
  localparam int RESERVOIR_BITS_DEF = 16;
  localparam int MAX_DEPTH          = 3;
  localparam int BPC_MAX            = (1 << BPC_W) - 1;
  localparam int QUEUE_DEPTH        = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD = 3'd4;

  // Register reset values
  localparam logic [BPC_W-1:0] RST_BPC  = 2'd1;
  localparam logic [CH_W-1:0]  RST_CHAN = 3'd3;

  // Modes and item kinds
  localparam logic MODE_EMBED    = 1'b0;
  localparam logic MODE_EXTRACT  = 1'b1;
  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_CHANNEL  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_CAPACITY = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERRUN = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  // Operation classes decided by the front end
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_EMBED   = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
  localparam logic [OP_W-1:0] OP_SKIP    = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_image;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_payload;
    logic              last_payload;
    logic [ST_W-1:0]   status;
  } out_item_t;

  // Classified item held in the queue between front and back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              over_cap;
    logic [BPC_W-1:0]  depth;
  } q_entry_t;

  // Effective depth: zero acts as one, clamp at MAX_DEPTH
  function automatic logic [BPC_W-1:0] depth_used(input logic [BPC_W-1:0] bpc);
    logic [BPC_W-1:0] d;
    d = (bpc == '0) ? BPC_W'(1) : bpc;
    if (int'(d) > MAX_DEPTH) d = BPC_W'(MAX_DEPTH);
    return d;
  endfunction

endpackage

/* rtl/core/lsbst_front.sv */
// ----------------------------------------------------------------------------
// lsbst_front
// Classifies an incoming item by kind and mode, resolves the effective depth
// and evaluates the capacity check against the current configuration.
// ----------------------------------------------------------------------------
module lsbst_front (
  input  lsbst_pkg::in_item_t          in_item,
  input  logic                         mode,
  input  logic [lsbst_pkg::BPC_W-1:0]  bits_per_channel,
  input  logic [lsbst_pkg::CH_W-1:0]   channel_count,
  input  logic [lsbst_pkg::PIX_W-1:0]  pixel_count,
  input  logic [lsbst_pkg::PAY_W-1:0]  payload_bytes,
  output lsbst_pkg::q_entry_t          entry
);
  import lsbst_pkg::*;

  localparam int CHD_W  = 4;               // channels (<=4) times depth (<=3)
  localparam int PROD_W = PIX_W + CHD_W;

  logic [BPC_W-1:0]  depth;
  logic [CH_W-1:0]   ch_eff;
  logic [CHD_W-1:0]  ch_depth;
  logic [PROD_W-1:0] cap_bits;
  logic [PROD_W-1:0] need_bits;
  logic              over_cap;
  logic [OP_W-1:0]   op;

  assign depth = depth_used(bits_per_channel);

  // Capacity: payload*8 > pixels*channels*depth, zero below three channels
  always_comb begin
    ch_eff    = (channel_count > CH_W'(4)) ? CH_W'(4) : channel_count;
    ch_depth  = CHD_W'(ch_eff) * CHD_W'(depth);
    cap_bits  = PROD_W'(pixel_count) * PROD_W'(ch_depth);
    need_bits = PROD_W'({payload_bytes, 3'b000});
    if (ch_eff < CH_W'(3)) begin
      over_cap = (payload_bytes != '0);
    end else begin
      over_cap = (need_bits > cap_bits);
    end
  end

  // Operation class
  always_comb begin
    if (in_item.kind == KIND_PAYLOAD) begin
      op = (mode == MODE_EMBED) ? OP_PUSH : OP_SKIP;
    end else begin
      op = (mode == MODE_EMBED) ? OP_EMBED : OP_EXTRACT;
    end
  end

  assign entry.op       = op;
  assign entry.data     = in_item.data_byte;
  assign entry.first    = in_item.first_of_image;
  assign entry.over_cap = over_cap;
  assign entry.depth    = depth;

endmodule

/* rtl/core/lsbst_fifo.sv */
// ----------------------------------------------------------------------------
// lsbst_fifo
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module lsbst_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsbst_pkg::q_entry_t  wr_entry,
  input  logic                 pop,
  output lsbst_pkg::q_entry_t  rd_entry,
  output logic                 rd_valid,
  output logic                 full
);
  import lsbst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign rd_valid = (cnt_r != '0);
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign rd_entry = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

/* rtl/core/lsbst_back.sv */
// ----------------------------------------------------------------------------
// lsbst_back
// Executes classified items one per cycle unless a result waits on a stalled
// output: bit reservoir, embedding, gathering of extracted bits, result stage.
// ----------------------------------------------------------------------------
module lsbst_back #(
  parameter int RESERVOIR_BITS = lsbst_pkg::RESERVOIR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lsbst_pkg::q_entry_t          q_entry,
  input  logic [lsbst_pkg::PAY_W-1:0]  payload_bytes,
  output logic                         pop,
  output logic                         out_valid,
  output lsbst_pkg::out_item_t         out_data,
  input  logic                         out_stall
);
  import lsbst_pkg::*;

  localparam int FILL_W = $clog2(RESERVOIR_BITS + 1);
  localparam int IDX_W  = $clog2(RESERVOIR_BITS);

  // Stream state
  logic [RESERVOIR_BITS-1:0] res_r, res_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic [DONE_W-1:0]         done_r, done_nxt;
  logic [BYTE_W-1:0]         gbyte_r, gbyte_nxt;
  logic [GFILL_W-1:0]        gfill_r, gfill_nxt;

  // Result stage
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  // State seen by this item, after an optional new-image clear
  logic [RESERVOIR_BITS-1:0] res_e;
  logic [FILL_W-1:0]         fill_e;
  logic [DONE_W-1:0]         done_e;
  logic [BYTE_W-1:0]         gbyte_e;
  logic [GFILL_W-1:0]        gfill_e;

  logic [DONE_W-1:0]         total;
  logic [DONE_W-1:0]         remaining;
  logic [BPC_W-1:0]          n;
  logic                      fill_lt_n;
  logic                      push_over;
  logic                      is_last;
  logic [BYTE_W-1:0]         emb_byte;
  logic [BYTE_W-1:0]         g_byte;
  logic [GFILL_W:0]          g_fill;
  logic                      g_emit;
  logic [BYTE_W-1:0]         g_done;
  logic                      has_res;
  out_item_t                 res_item;
  logic                      out_free;

  always_comb begin
    res_e   = q_entry.first ? '0 : res_r;
    fill_e  = q_entry.first ? '0 : fill_r;
    done_e  = q_entry.first ? '0 : done_r;
    gbyte_e = q_entry.first ? '0 : gbyte_r;
    gfill_e = q_entry.first ? '0 : gfill_r;
  end

  // Bits still to move and bits taken by this channel byte
  always_comb begin
    total     = {payload_bytes, 3'b000};
    remaining = (done_e < total) ? total - done_e : '0;
    n         = (remaining < DONE_W'(q_entry.depth)) ? remaining[BPC_W-1:0] : q_entry.depth;
    fill_lt_n = (fill_e < FILL_W'(n));
    push_over = ({1'b0, fill_e} + (FILL_W + 1)'(BYTE_W)) > (FILL_W + 1)'(RESERVOIR_BITS);
    is_last   = (DONE_W'(n) == remaining);
  end

  // Embed: oldest reservoir bit goes to bit 0, next to bit 1, and so on
  always_comb begin
    logic [IDX_W-1:0] bit_idx;
    emb_byte = q_entry.data;
    bit_idx  = '0;
    for (int b = 0; b < BPC_MAX; b++) begin
      if (b < int'(n)) begin
        bit_idx     = IDX_W'(fill_e - FILL_W'(b + 1));
        emb_byte[b] = res_e[bit_idx];
      end
    end
  end

  // Extract: shift low bits into the gather byte, flush at eight
  always_comb begin
    g_byte = gbyte_e;
    g_fill = {1'b0, gfill_e};
    g_emit = 1'b0;
    g_done = '0;
    for (int b = 0; b < BPC_MAX; b++) begin
      if (b < int'(n)) begin
        g_byte = {g_byte[BYTE_W-2:0], q_entry.data[b]};
        g_fill = g_fill + (GFILL_W + 1)'(1);
        if (g_fill == (GFILL_W + 1)'(BYTE_W)) begin
          g_emit = 1'b1;
          g_done = g_byte;
          g_byte = '0;
          g_fill = '0;
        end
      end
    end
  end

  // Per-operation result and next state
  always_comb begin
    has_res   = 1'b0;
    res_item  = '0;
    res_nxt   = res_e;
    fill_nxt  = fill_e;
    done_nxt  = done_e;
    gbyte_nxt = gbyte_e;
    gfill_nxt = gfill_e;
    case (q_entry.op)
      OP_PUSH: begin
        // only bytes still needed enter the reservoir
        if (remaining != '0 && DONE_W'(fill_e) < remaining) begin
          if (push_over) begin
            has_res         = 1'b1;
            res_item.status = ST_OVERFLOW;
          end else begin
            res_nxt  = RESERVOIR_BITS'({res_e, q_entry.data});
            fill_nxt = fill_e + FILL_W'(BYTE_W);
          end
        end
      end
      OP_EMBED: begin
        has_res           = 1'b1;
        res_item.out_byte = q_entry.data;
        if (remaining == '0) begin
          res_item.status = ST_OK;
        end else if (q_entry.over_cap) begin
          res_item.status = ST_CAPACITY;
        end else if (fill_lt_n) begin
          res_item.status = ST_UNDERRUN;
        end else begin
          // bits above the fill level are never read, so no masking
          res_item.out_byte     = emb_byte;
          res_item.last_payload = is_last;
          fill_nxt              = fill_e - FILL_W'(n);
          done_nxt              = done_e + DONE_W'(n);
        end
      end
      OP_EXTRACT: begin
        if (remaining != '0) begin
          if (q_entry.over_cap) begin
            has_res         = 1'b1;
            res_item.status = ST_CAPACITY;
          end else begin
            gbyte_nxt = g_byte;
            gfill_nxt = g_fill[GFILL_W-1:0];
            done_nxt  = done_e + DONE_W'(n);
            if (g_emit) begin
              has_res               = 1'b1;
              res_item.out_byte     = g_done;
              res_item.is_payload   = 1'b1;
              res_item.last_payload = is_last;
            end
          end
        end
      end
      OP_SKIP: begin
        // payload byte in extract mode: only the new-image clear applies
      end
      default: begin
      end
    endcase
  end

  // Item leaves the queue when its result, if any, has a place to go
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && (!has_res || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r       <= '0;
      fill_r      <= '0;
      done_r      <= '0;
      gbyte_r     <= '0;
      gfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        res_r   <= res_nxt;
        fill_r  <= fill_nxt;
        done_r  <= done_nxt;
        gbyte_r <= gbyte_nxt;
        gfill_r <= gfill_nxt;
      end
      if (out_free) begin
        out_valid_r <= pop && has_res;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* rtl/core/lsb_stego_embed_extract.sv */
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// Each accepted item is written into the queue; the back end registers its result.
// One item per cycle unless stalled: the back end retires one queued item a cycle.
// A four-entry queue decouples input stall from output stall.
// Reset (rst_n low, synchronous) clears queue, stream state and result valid,
// and loads the configuration reset values.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract #(
  parameter int RESERVOIR_BITS = lsbst_pkg::RESERVOIR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsbst_pkg::in_item_t               in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsbst_pkg::out_item_t              out_data,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsbst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsbst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lsbst_pkg::*;

  // Configuration registers
  logic              mode_r;
  logic [BPC_W-1:0]  bpc_r;
  logic [CH_W-1:0]   chan_r;
  logic [PIX_W-1:0]  pix_r;
  logic [PAY_W-1:0]  pay_r;

  q_entry_t          front_entry;
  q_entry_t          head_entry;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic              q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EMBED;
      bpc_r  <= RST_BPC;
      chan_r <= RST_CHAN;
      pix_r  <= '0;
      pay_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:    mode_r <= cfg_wdata[0];
        CFG_BPC:     bpc_r  <= cfg_wdata[BPC_W-1:0];
        CFG_CHAN:    chan_r <= cfg_wdata[CH_W-1:0];
        CFG_PIXELS:  pix_r  <= cfg_wdata[PIX_W-1:0];
        CFG_PAYLOAD: pay_r  <= cfg_wdata[PAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the incoming item
  lsbst_front u_front (
    .in_item          (in_data),
    .mode             (mode_r),
    .bits_per_channel (bpc_r),
    .channel_count    (chan_r),
    .pixel_count      (pix_r),
    .payload_bytes    (pay_r),
    .entry            (front_entry)
  );

  // Queue between front and back
  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  lsbst_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (front_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .rd_valid (q_valid),
    .full     (q_full)
  );

  // Back end: stream state and result register
  lsbst_back #(
    .RESERVOIR_BITS (RESERVOIR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .payload_bytes (pay_r),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lsb_stego_embed_extract. A scoreboard class tracks
// the reservoir, gather and progress state of the stego stream. It computes
// the expected byte and status for each accepted item that yields a result,
// and compares each result transfer field by field. A short directed part
// covers the special cases, then random image streams run under a range of
// configurations and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import lsbst_pkg::*;

  localparam int RES_BITS       = RESERVOIR_BITS_DEF;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_PHASES       = 18;
  localparam int PHASE_QUOTA    = 35;
  localparam int PRESSURE_PHASE = 5;
  localparam int DRAIN_PHASE    = 6;

  // Tracks the stego stream state and the queue of expected result bytes
  class lsb_stream_tracker;
    logic                mode;
    logic [BPC_W-1:0]    bpc;
    logic [CH_W-1:0]     chans;
    logic [PIX_W-1:0]    pixels;
    logic [PAY_W-1:0]    pay_len;
    logic [RES_BITS-1:0] reservoir;
    int unsigned         res_fill;
    int unsigned         bits_done;
    logic [BYTE_W-1:0]   gather;
    int unsigned         gather_fill;
    out_item_t           pending_bytes[$];
    int                  errors;
    int                  items_seen;
    int                  results_seen;
    int                  status_hits[4];
    int                  extracted;
    int                  last_hits;

    function new();
      mode    = MODE_EMBED;
      bpc     = RST_BPC;
      chans   = RST_CHAN;
      pixels  = '0;
      pay_len = '0;
      clear_stream();
    endfunction

    function void clear_stream();
      reservoir   = '0;
      res_fill    = 0;
      bits_done   = 0;
      gather      = '0;
      gather_fill = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:    mode    = val[0];
        CFG_BPC:     bpc     = val[BPC_W-1:0];
        CFG_CHAN:    chans   = val[CH_W-1:0];
        CFG_PIXELS:  pixels  = val[PIX_W-1:0];
        CFG_PAYLOAD: pay_len = val[PAY_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, clamp at the deepest supported depth
    function int unsigned depth_now();
      int unsigned d;
      d = bpc;
      if (d < 1) d = 1;
      if (d > MAX_DEPTH) d = MAX_DEPTH;
      return d;
    endfunction

    function int unsigned bits_left();
      int unsigned total;
      total = pay_len * 32'd8;
      return (bits_done < total) ? total - bits_done : 0;
    endfunction

    function bit over_capacity();
      longint unsigned ch, cap;
      ch = chans;
      if (ch > 4) ch = 4;
      cap = (ch < 3) ? 0 : (longint'(pixels) * ch * depth_now()) / 8;
      return longint'(pay_len) > cap;
    endfunction

    function int unsigned step_bits();
      int unsigned n;
      n = depth_now();
      if (n > bits_left()) n = bits_left();
      return n;
    endfunction

    // stimulus hints
    function bit embedding();
      return mode == MODE_EMBED;
    endfunction
    function bit short_of_bits();
      return bits_left() != 0 && res_fill < step_bits();
    endfunction
    function bit room_for_byte();
      return res_fill + 8 <= RES_BITS;
    endfunction
    function bit finished();
      return bits_left() == 0;
    endfunction

    function void expect_byte(logic [BYTE_W-1:0] b, logic isp, logic last,
                              logic [ST_W-1:0] st);
      out_item_t r;
      r.out_byte     = b;
      r.is_payload   = isp;
      r.last_payload = last;
      r.status       = st;
      pending_bytes.push_back(r);
    endfunction

    // Applies one accepted item; returns 1 when the item had any effect
    function bit note_transfer(in_item_t it);
      int unsigned       left, n;
      logic [BYTE_W-1:0] b;
      bit                emit;
      logic [BYTE_W-1:0] done_byte;
      bit                touched;
      touched = it.first_of_image;
      b = it.data_byte;
      emit = 0;
      done_byte = '0;
      if (it.first_of_image) clear_stream();
      left = bits_left();

      if (it.kind == KIND_PAYLOAD) begin
        // dropped: extract mode, payload done or reservoir already covers it
        if (mode != MODE_EMBED || left == 0 || res_fill >= left) return touched;
        if (res_fill + 8 > RES_BITS) begin
          expect_byte('0, 1'b0, 1'b0, ST_OVERFLOW);
        end else begin
          reservoir = (reservoir << 8) | RES_BITS'(b);
          res_fill += 8;
        end
        items_seen++;
        return 1;
      end

      if (mode == MODE_EMBED) begin
        items_seen++;
        if (left == 0) begin
          expect_byte(b, 1'b0, 1'b0, ST_OK);
          return 1;
        end
        if (over_capacity()) begin
          expect_byte(b, 1'b0, 1'b0, ST_CAPACITY);
          return 1;
        end
        n = step_bits();
        if (res_fill < n) begin
          expect_byte(b, 1'b0, 1'b0, ST_UNDERRUN);
          return 1;
        end
        // oldest reservoir bit lands in bit 0
        for (int i = 0; i < n; i++) b[i] = reservoir[res_fill - 1 - i];
        res_fill -= n;
        for (int i = res_fill; i < RES_BITS; i++) reservoir[i] = 1'b0;
        bits_done += n;
        expect_byte(b, 1'b0, bits_left() == 0, ST_OK);
        return 1;
      end

      // extract mode
      if (left == 0) return touched;
      items_seen++;
      if (over_capacity()) begin
        expect_byte('0, 1'b0, 1'b0, ST_CAPACITY);
        return 1;
      end
      n = step_bits();
      for (int i = 0; i < n; i++) begin
        gather = {gather[BYTE_W-2:0], b[i]};
        gather_fill++;
        if (gather_fill == 8) begin
          emit = 1;
          done_byte = gather;
          gather = '0;
          gather_fill = 0;
        end
      end
      bits_done += n;
      if (emit) expect_byte(done_byte, 1'b1, bits_left() == 0, ST_OK);
      return 1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        $error("result %02h/%0b/%0b/%0d arrived with nothing expected",
               got.out_byte, got.is_payload, got.last_payload, got.status);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      results_seen++;
      status_hits[got.status]++;
      if (got.is_payload) extracted++;
      if (got.last_payload) last_hits++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_payload !== want.is_payload) begin
        $error("is_payload: expected %0b, got %0b", want.is_payload, got.is_payload);
        errors++;
      end
      if (got.last_payload !== want.last_payload) begin
        $error("last_payload: expected %0b, got %0b", want.last_payload, got.last_payload);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsb_stream_tracker tracker = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int n_directed;
  int n_random;
  int n_configs;

  lsb_stego_embed_extract uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #10 clk = ~clk;

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lsb_stego_embed_extract verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(input in_item_t it, inout int counted);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    void'(tracker.note_transfer(it));
    counted++;
  endtask

  task automatic send_fields(input logic k, input logic [BYTE_W-1:0] d, input logic f);
    in_item_t it;
    it.kind           = k;
    it.data_byte      = d;
    it.first_of_image = f;
    send_item(it, n_directed);
  endtask

  // stop sending, wait for every expected result, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(input logic m, input logic [BPC_W-1:0] bpc,
                           input logic [CH_W-1:0] ch, input logic [PIX_W-1:0] pix,
                           input logic [PAY_W-1:0] pay);
    wait_drained();
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_BPC, CFG_DATA_W'(bpc));
    write_reg(CFG_CHAN, CFG_DATA_W'(ch));
    write_reg(CFG_PIXELS, CFG_DATA_W'(pix));
    write_reg(CFG_PAYLOAD, CFG_DATA_W'(pay));
    cfg_valid <= 1'b0;
    n_configs++;
  endtask

  // mostly well-formed image streams, some noise
  task automatic stream_image(input int quota, input bit pause_mid);
    in_item_t it;
    int       counted, tries;
    bit       fresh, paused;
    counted = 0;
    tries   = 0;
    fresh   = 1;
    paused  = 0;
    while (counted < quota && tries < quota * 4) begin
      it.data_byte = BYTE_W'($urandom_range(255));
      if ($urandom_range(99) < 12) begin
        it.kind           = 1'($urandom_range(1));
        it.first_of_image = fresh | ($urandom_range(29) == 0);
      end else begin
        it.first_of_image = fresh;
        if (tracker.embedding())
          it.kind = (tracker.short_of_bits() ||
                     (tracker.room_for_byte() && $urandom_range(99) < 20)) ?
                    KIND_PAYLOAD : KIND_CHANNEL;
        else
          it.kind = ($urandom_range(99) < 4) ? KIND_PAYLOAD : KIND_CHANNEL;
      end
      fresh = 0;
      send_item(it, counted);
      tries++;
      if (tracker.finished() && $urandom_range(99) < 30) fresh = 1;
      if (pause_mid && !paused && counted >= quota / 2) begin
        paused = 1;
        wait_drained();
      end
    end
    n_random += counted;
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask       = 0;
    n_directed     = 0;
    n_random       = 0;
    n_configs      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty payload, so channels pass through
    send_fields(KIND_CHANNEL, 8'h00, 1'b1);
    send_fields(KIND_CHANNEL, 8'hFF, 1'b0);
    send_fields(KIND_PAYLOAD, 8'h5A, 1'b0);

    // embed a three-byte payload at depth three: reservoir overflow then underrun
    configure(MODE_EMBED, 2'd3, 3'd4, 25'd100, 24'd3);
    send_fields(KIND_PAYLOAD, 8'hA5, 1'b1);
    send_fields(KIND_CHANNEL, 8'hFF, 1'b0);
    send_fields(KIND_PAYLOAD, 8'h3C, 1'b0);
    send_fields(KIND_PAYLOAD, 8'hC3, 1'b0);
    send_fields(KIND_CHANNEL, 8'h00, 1'b0);
    send_fields(KIND_CHANNEL, 8'hFF, 1'b0);
    send_fields(KIND_CHANNEL, 8'h55, 1'b0);
    send_fields(KIND_CHANNEL, 8'hAA, 1'b0);
    send_fields(KIND_CHANNEL, 8'h00, 1'b0);

    // extract one byte, channel count above four, then payload finished
    configure(MODE_EXTRACT, 2'd2, 3'd7, 25'd1, 24'd1);
    send_fields(KIND_CHANNEL, 8'h02, 1'b1);
    send_fields(KIND_CHANNEL, 8'hFD, 1'b0);
    send_fields(KIND_CHANNEL, 8'h01, 1'b0);
    send_fields(KIND_CHANNEL, 8'hFE, 1'b0);
    send_fields(KIND_CHANNEL, 8'h77, 1'b0);
    send_fields(KIND_PAYLOAD, 8'h81, 1'b0);

    // zero capacity with two channels, depth zero, both modes
    configure(MODE_EXTRACT, 2'd0, 3'd2, 25'd100, 24'd1);
    send_fields(KIND_CHANNEL, 8'h3E, 1'b1);
    configure(MODE_EMBED, 2'd0, 3'd2, 25'd100, 24'd1);
    send_fields(KIND_CHANNEL, 8'hC1, 1'b1);

    // random phases
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: configure(MODE_EMBED, 2'd3, 3'd4, 25'h1000000, 24'hFFFFFF);
        1: configure(MODE_EXTRACT, 2'd3, 3'd4, 25'h1000000, 24'hFFFFFF);
        2: configure(MODE_EMBED, 2'd1, 3'd3, 25'h1FFFFFF, 24'd0);
        3: configure(MODE_EXTRACT, 2'd0, 3'd1, 25'd0, 24'd1);
        PRESSURE_PHASE: configure(MODE_EMBED, 2'd2, 3'd3, 25'd64, 24'd4);
        default: configure(1'($urandom_range(1)), BPC_W'($urandom_range(3)),
                           CH_W'(($urandom_range(99) < 75) ? $urandom_range(3, 4)
                                                           : $urandom_range(7)),
                           PIX_W'(($urandom_range(99) < 85) ? $urandom_range(1, 64)
                                                            : $urandom_range(3)),
                           PAY_W'(($urandom_range(99) < 90) ? $urandom_range(5)
                                                            : $urandom_range(6, 40)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 45; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == PRESSURE_PHASE) begin
        send_idle_pct = 0;
        hold_ask <= hold_ask + 1;
      end
      stream_image(PHASE_QUOTA, p == DRAIN_PHASE);
    end

    wait_drained();
    $display("Run covered %0d directed and %0d random items over %0d register settings;",
             n_directed, n_random, n_configs);
    $display("%0d results: ok %0d, cap %0d, underrun %0d, overflow %0d, extracted %0d, ends %0d",
             tracker.results_seen, tracker.status_hits[ST_OK], tracker.status_hits[ST_CAPACITY],
             tracker.status_hits[ST_UNDERRUN], tracker.status_hits[ST_OVERFLOW],
             tracker.extracted, tracker.last_hits);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("lsb_stego_embed_extract verification clean");
    end else begin
      $display("lsb_stego_embed_extract verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lsbst_pkg.sv
rtl/core/lsbst_front.sv
rtl/core/lsbst_fifo.sv
rtl/core/lsbst_back.sv
rtl/core/lsb_stego_embed_extract.sv
bench/testbench.sv
